// ===== design/cwd_pkg.sv =====
// ---------------------------------------------------------------------------
// Cubic waveshaper package
// Widths, register indexes, fixed-point constants and the sequencer states
// shared by the cubic waveshape distortion block.
// ---------------------------------------------------------------------------
`default_nettype none

package cwd_pkg;

  // Field and port widths.
  localparam int SAMPLE_W   = 16;
  localparam int PEAK_W     = 15;
  localparam int LEVEL_W    = 16;
  localparam int GAIN_W     = 13;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_ENABLE     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MIX_LEVEL  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DRIVE_GAIN = 2'd2;

  // Register limits.
  localparam logic [LEVEL_W-1:0] LEVEL_FULL = 16'd32768;
  localparam logic [GAIN_W-1:0]  GAIN_MIN   = 13'd2560;
  localparam logic [GAIN_W-1:0]  GAIN_MAX   = 13'd5120;

  // Shared multiplier: 17 x 17 unsigned magnitudes.
  localparam int MUL_W  = 17;
  localparam int PROD_W = 2 * MUL_W;

  // Q1.16 unity, the clamp bound of the driven signal.
  localparam logic [MUL_W-1:0] Q16_ONE   = 17'd65536;
  // Final rescale factor toward the 16-bit range.
  localparam logic [MUL_W-1:0] OUT_SCALE = 17'd32767;

  // Threshold and makeup-gain ratios, found by long division.
  localparam int RATIO_W    = 14;
  localparam int DIV_W      = 27;
  localparam int DIV_STEPS  = DIV_W;
  localparam int DIV_CNT_W  = $clog2(DIV_STEPS);
  localparam int THR_NUM    = 2 * 256 * 65536;
  localparam int COMP_NUM   = 5 * 256 * 65536;
  localparam int THR_RESET  = THR_NUM / (2560 + 256);
  localparam int COMP_RESET = COMP_NUM / (768 + 2 * 2560);

  // Sample sequencer states.
  typedef enum logic [8:0] {
    ST_IDLE   = 9'b000000001,
    ST_DRIVE  = 9'b000000010,
    ST_SQUARE = 9'b000000100,
    ST_CUBE   = 9'b000001000,
    ST_WET    = 9'b000010000,
    ST_DRY    = 9'b000100000,
    ST_MIX    = 9'b001000000,
    ST_SCALE  = 9'b010000000,
    ST_FINISH = 9'b100000000
  } state_t;

endpackage

`default_nettype wire

// ===== design/cubic_waveshape_distortion.sv =====
// ---------------------------------------------------------------------------
// Cubic waveshape distortion
// Drive, sign-preserving cubic shaper, hard clip, makeup gain, dry/wet mix
// and per-buffer peak tracking on a stream of signed 16-bit samples.
// ---------------------------------------------------------------------------
// A processed sample reaches the result register once one 17x17 multiplier
// has been stepped through seven products (drive, square, cube, makeup gain,
// dry, wet, rescale) and then a finishing step. The sequencer then returns to
// idle, and a new request is taken only once the previous one has left the
// sequencer. In bypass (enable low or mix level zero) the sequencer goes from
// idle straight to the finishing step. Writing drive_gain starts a long
// division (27 steps each for the clip threshold and the makeup gain), and
// sample requests are stalled until it completes, as they are during any
// register write and during reset. A result sits in an output register, so
// the next request is taken while the previous result waits on a stalled
// output.
`default_nettype none

module cubic_waveshape_distortion (
  input  logic                                clk,
  input  logic                                rst,
  // Configuration write port.
  input  logic                                wr_en,
  input  logic [cwd_pkg::CFG_IDX_W-1:0]       wr_index,
  input  logic [cwd_pkg::CFG_DATA_W-1:0]      wr_data,
  // Sample request channel.
  input  logic                                sample_valid,
  output logic                                sample_stall,
  input  logic signed [cwd_pkg::SAMPLE_W-1:0] sample_in,
  input  logic                                buffer_end,
  // Result channel.
  output logic                                result_valid,
  input  logic                                result_stall,
  output logic signed [cwd_pkg::SAMPLE_W-1:0] sample_out,
  output logic [cwd_pkg::PEAK_W-1:0]          peak_level,
  output logic                                end_out
);
  import cwd_pkg::*;

  // Configuration registers and derived ratios.
  logic                 enable;
  logic [LEVEL_W-1:0]   mix_level;
  logic [GAIN_W-1:0]    drive_gain;
  logic [RATIO_W-1:0]   thr;
  logic [RATIO_W-1:0]   comp;

  // Long divider.
  logic                 div_busy;
  logic                 div_phase;
  logic [DIV_CNT_W-1:0] div_cnt;
  logic [RATIO_W-1:0]   div_rem;
  logic [DIV_W-1:0]     div_quo;
  logic [RATIO_W-1:0]   div_divisor;
  logic [RATIO_W:0]     div_trial;
  logic                 div_take;
  logic [RATIO_W-1:0]   div_rem_next;
  logic [DIV_W-1:0]     div_quo_next;
  logic                 div_last;
  logic                 gain_write;

  // Sample sequencer.
  state_t               state;
  state_t               state_next;
  logic                 sample_take;
  logic                 bypass_now;
  logic                 bypass;
  logic                 sign_neg;
  logic                 end_flag;
  logic [SAMPLE_W-1:0]  sample_hold;
  logic [SAMPLE_W-1:0]  sample_raw;
  logic [SAMPLE_W-1:0]  in_mag;
  logic [MUL_W-1:0]     twice;
  logic [MUL_W-1:0]     clean_next;
  logic [MUL_W-1:0]     clean_mag;
  logic [MUL_W-1:0]     amag;
  logic [MUL_W-1:0]     wet;

  // Shared multiply-accumulate unit.
  logic [MUL_W-1:0]     mul_a;
  logic [MUL_W-1:0]     mul_b;
  logic                 acc_add;
  logic [PROD_W-1:0]    product;
  logic [PROD_W-1:0]    acc;
  logic [PROD_W-1:0]    acc_next;
  logic [MUL_W-1:0]     drive_lim;
  logic [MUL_W-1:0]     cube_lim;

  // Result and peak tracking.
  logic [PEAK_W-1:0]    out_mag;
  logic [PEAK_W-1:0]    peak_max;
  logic [PEAK_W-1:0]    running_peak;
  logic                 out_free;

  // Handshake on the request side.
  assign sample_stall = rst || (state != ST_IDLE) || div_busy || wr_en;
  assign sample_take  = sample_valid && !sample_stall;
  assign out_free     = !result_valid || !result_stall;
  assign gain_write   = wr_en && (wr_index == REG_DRIVE_GAIN);

  // Long divider: one restoring step per cycle, threshold first, then makeup.
  always_comb begin
    if (div_phase) begin
      div_divisor = {1'b0, drive_gain} + {1'b0, drive_gain} + 14'd768;
    end else begin
      div_divisor = {1'b0, drive_gain} + 14'd256;
    end
    div_trial    = {div_rem, div_quo[DIV_W-1]};
    div_take     = div_trial >= {1'b0, div_divisor};
    div_rem_next = div_take ? RATIO_W'(div_trial - {1'b0, div_divisor})
                            : div_trial[RATIO_W-1:0];
    div_quo_next = {div_quo[DIV_W-2:0], div_take};
    div_last     = div_cnt == DIV_CNT_W'(DIV_STEPS - 1);
  end

  // Configuration registers, divider control and the ratio results.
  always_ff @(posedge clk) begin
    if (rst) begin
      enable     <= 1'b0;
      mix_level  <= '0;
      drive_gain <= GAIN_MIN;
      thr        <= RATIO_W'(THR_RESET);
      comp       <= RATIO_W'(COMP_RESET);
      div_busy   <= 1'b0;
      div_phase  <= 1'b0;
      div_cnt    <= '0;
    end else begin
      if (wr_en) begin
        case (wr_index)
          REG_ENABLE: begin
            enable <= wr_data[0];
          end
          REG_MIX_LEVEL: begin
            mix_level <= (wr_data > LEVEL_FULL) ? LEVEL_FULL : wr_data;
          end
          REG_DRIVE_GAIN: begin
            if (wr_data[GAIN_W-1:0] < GAIN_MIN) begin
              drive_gain <= GAIN_MIN;
            end else if (wr_data[GAIN_W-1:0] > GAIN_MAX) begin
              drive_gain <= GAIN_MAX;
            end else begin
              drive_gain <= wr_data[GAIN_W-1:0];
            end
          end
          default: begin
          end
        endcase
      end
      if (gain_write) begin
        div_busy  <= 1'b1;
        div_phase <= 1'b0;
        div_cnt   <= '0;
      end else if (div_busy) begin
        if (div_last) begin
          div_cnt <= '0;
          if (div_phase) begin
            comp     <= div_quo_next[RATIO_W-1:0];
            div_busy <= 1'b0;
          end else begin
            thr       <= div_quo_next[RATIO_W-1:0];
            div_phase <= 1'b1;
          end
        end else begin
          div_cnt <= div_cnt + DIV_CNT_W'(1);
        end
      end
    end
  end

  // Divider datapath: remainder and dividend/quotient shift register.
  always_ff @(posedge clk) begin
    if (gain_write || (div_busy && div_last && !div_phase)) begin
      div_rem <= '0;
      div_quo <= gain_write ? DIV_W'(THR_NUM) : DIV_W'(COMP_NUM);
    end else if (div_busy) begin
      div_rem <= div_rem_next;
      div_quo <= div_quo_next;
    end
  end

  // Input magnitude and its Q1.16 form: 2x + floor(2x / 32767) is x*65536/32767.
  always_comb begin
    sample_raw = sample_in;
    in_mag     = sample_raw[SAMPLE_W-1] ? SAMPLE_W'(~sample_raw + 16'd1) : sample_raw;
    twice      = {in_mag, 1'b0};
    if (twice >= 17'd65534) begin
      clean_next = twice + 17'd2;
    end else if (twice >= 17'd32767) begin
      clean_next = twice + 17'd1;
    end else begin
      clean_next = twice;
    end
    bypass_now = !enable || (mix_level == '0);
  end

  // Clamps applied to the previous product before it feeds the multiplier.
  always_comb begin
    if (acc[PROD_W-1:8] > (PROD_W - 8)'(Q16_ONE)) begin
      drive_lim = Q16_ONE;
    end else begin
      drive_lim = acc[MUL_W+7:8];
    end
    if (acc[32:16] > {3'b000, thr}) begin
      cube_lim = {3'b000, thr};
    end else begin
      cube_lim = acc[32:16];
    end
  end

  // Operand selection for the shared multiplier.
  always_comb begin
    mul_a   = '0;
    mul_b   = '0;
    acc_add = 1'b0;
    case (state)
      ST_DRIVE: begin
        mul_a = clean_mag;
        mul_b = {4'b0000, drive_gain};
      end
      ST_SQUARE: begin
        mul_a = drive_lim;
        mul_b = drive_lim;
      end
      ST_CUBE: begin
        mul_a = acc[32:16];
        mul_b = amag;
      end
      ST_WET: begin
        mul_a = cube_lim;
        mul_b = {3'b000, comp};
      end
      ST_DRY: begin
        mul_a = clean_mag;
        mul_b = {1'b0, LEVEL_FULL} - {1'b0, mix_level};
      end
      ST_MIX: begin
        mul_a   = wet;
        mul_b   = {1'b0, mix_level};
        acc_add = 1'b1;
      end
      ST_SCALE: begin
        mul_a = acc[31:15];
        mul_b = OUT_SCALE;
      end
      default: begin
      end
    endcase
    product  = mul_a * mul_b;
    acc_next = product + (acc_add ? acc : '0);
  end

  // Sequencer next state.
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (sample_take) begin
          state_next = bypass_now ? ST_FINISH : ST_DRIVE;
        end
      end
      ST_DRIVE:  state_next = ST_SQUARE;
      ST_SQUARE: state_next = ST_CUBE;
      ST_CUBE:   state_next = ST_WET;
      ST_WET:    state_next = ST_DRY;
      ST_DRY:    state_next = ST_MIX;
      ST_MIX:    state_next = ST_SCALE;
      ST_SCALE:  state_next = ST_FINISH;
      ST_FINISH: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Per-sample working registers.
  always_ff @(posedge clk) begin
    if (sample_take) begin
      sample_hold <= sample_in;
      sign_neg    <= sample_in[SAMPLE_W-1];
      end_flag    <= buffer_end;
      bypass      <= bypass_now;
      clean_mag   <= clean_next;
    end
    if (state == ST_SQUARE) begin
      amag <= drive_lim;
    end
    if (state == ST_DRY) begin
      wet <= acc[32:16];
    end
    if ((state != ST_IDLE) && (state != ST_FINISH)) begin
      acc <= acc_next;
    end
  end

  // Output magnitude and the peak including this sample.
  assign out_mag  = acc[30:16];
  assign peak_max = (out_mag > running_peak) ? out_mag : running_peak;

  // Result register and running peak.
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
      running_peak <= '0;
    end else begin
      if ((state == ST_FINISH) && out_free) begin
        result_valid <= 1'b1;
        if (end_flag) begin
          running_peak <= '0;
        end else if (!bypass) begin
          running_peak <= peak_max;
        end
      end else if (result_valid && !result_stall) begin
        result_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if ((state == ST_FINISH) && out_free) begin
      end_out <= end_flag;
      if (bypass) begin
        sample_out <= sample_hold;
        peak_level <= '0;
      end else begin
        sample_out <= sign_neg ? SAMPLE_W'(~{1'b0, out_mag} + 16'd1) : {1'b0, out_mag};
        peak_level <= end_flag ? peak_max : '0;
      end
    end
  end

  // A new result only appears out of the final sequencer step.
  assert property (@(posedge clk) disable iff (rst)
    $rose(result_valid) |-> $past(state == ST_FINISH))
    else $error("result appeared without a finishing step");

  // Peak is reported only with the buffer's last sample.
  assert property (@(posedge clk) disable iff (rst)
    (result_valid && !end_out) |-> (peak_level == '0))
    else $error("peak reported on a sample that does not end a buffer");

  // An accepted request always leaves the idle state.
  assert property (@(posedge clk) disable iff (rst)
    sample_take |=> (state != ST_IDLE))
    else $error("accepted request did not start the sequencer");

endmodule

`default_nettype wire
